FILE: src/vrc_pkg.sv
// Shared constants, types and helper functions of the voxel ray-cast occupancy block.
package vrc_pkg;

   localparam int MAP_X = 64;
   localparam int MAP_Y = 64;
   localparam int MAP_Z = 16;
   localparam int XW = $clog2(MAP_X);
   localparam int YW = $clog2(MAP_Y);
   localparam int ZW = $clog2(MAP_Z);
   localparam int DEPTH = MAP_X * MAP_Y * MAP_Z;
   localparam int AW = $clog2(DEPTH);

   localparam int CW = 10;
   localparam int PW = CW + 1;
   localparam int MW = 10;
   localparam int NW = 20;
   localparam int DSW = 20;
   localparam int TW = 11;
   localparam int FW = 12;
   localparam logic [FW-1:0] FREED_MAX = '1;

   localparam int OXW = 6;
   localparam int OYW = 6;
   localparam int OZW = 4;
   localparam int NLW = 16;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 16;

   localparam logic [1:0] ST_UNSEEN = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_OCCUPIED = 2'd2;
   localparam logic [1:0] ST_FRONTIER = 2'd3;

   typedef enum logic [1:0] {
      MODE_CAST  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_WRITE = 2'd3
   } mode_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_ORIGIN_X  = 2'd0,
      CSR_ORIGIN_Y  = 2'd1,
      CSR_ORIGIN_Z  = 2'd2,
      CSR_NEAR_SQ   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic     load;
      logic     clear;
      logic     rd_item;
      logic     cap_rd;
      logic     wr_item;
      logic     mark;
      logic     sq;
      axis_type sq_sel;
      logic     walk;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic near;
      logic walk_end;
   } status_type;

   function automatic logic in_bounds(input logic signed [PW-1:0] x,
                                      input logic signed [PW-1:0] y,
                                      input logic signed [PW-1:0] z);
      return !x[PW-1] && (x < PW'(MAP_X)) &&
             !y[PW-1] && (y < PW'(MAP_Y)) &&
             !z[PW-1] && (z < PW'(MAP_Z));
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic signed [PW-1:0] x,
                                               input logic signed [PW-1:0] y,
                                               input logic signed [PW-1:0] z);
      return AW'(z[ZW-1:0]) * AW'(MAP_X * MAP_Y) + AW'(y[YW-1:0]) * AW'(MAP_X) +
             AW'(x[XW-1:0]);
   endfunction

endpackage

FILE: src/vrc_ctrl.sv
// Controller state machine that sequences map accesses, clears and ray walks.
module vrc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_mode,
   input  vrc_pkg::status_type status,
   output vrc_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_READ,
      S_RDATA,
      S_WRITE,
      S_MARK,
      S_SQY,
      S_SQZ,
      S_NEAR,
      S_WALK
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = 1'b0;
      cmd = '0;
      cmd.sq_sel = vrc_pkg::AXIS_X;
      unique case (state_ff)
         S_INIT: begin
            cmd.clear = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (vrc_pkg::mode_type'(req_mode))
                  vrc_pkg::MODE_CAST:  state_in = S_MARK;
                  vrc_pkg::MODE_READ:  state_in = S_READ;
                  vrc_pkg::MODE_CLEAR: state_in = S_CLEAR;
                  vrc_pkg::MODE_WRITE: state_in = S_WRITE;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         S_READ: begin
            cmd.rd_item = 1'b1;
            state_in = S_RDATA;
         end
         S_RDATA: begin
            cmd.cap_rd = 1'b1;
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_WRITE: begin
            cmd.wr_item = 1'b1;
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            cmd.sq = 1'b1;
            cmd.sq_sel = vrc_pkg::AXIS_X;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.sq = 1'b1;
            cmd.sq_sel = vrc_pkg::AXIS_Y;
            state_in = S_SQZ;
         end
         S_SQZ: begin
            cmd.sq = 1'b1;
            cmd.sq_sel = vrc_pkg::AXIS_Z;
            state_in = S_NEAR;
         end
         S_NEAR: begin
            if (status.near) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_end) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/vrc_datapath.sv
// Datapath with the voxel map memory, configuration registers and the integer DDA walker.
module vrc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  vrc_pkg::cmd_type                  cmd,
   output vrc_pkg::status_type               status,
   input  logic [1:0]                        req_mode,
   input  logic signed [vrc_pkg::CW-1:0]     req_coord_x,
   input  logic signed [vrc_pkg::CW-1:0]     req_coord_y,
   input  logic signed [vrc_pkg::CW-1:0]     req_coord_z,
   input  logic [1:0]                        req_write_value,
   input  logic                              csr_we,
   input  logic [vrc_pkg::CSR_IW-1:0]        csr_index,
   input  logic [vrc_pkg::CSR_DW-1:0]        csr_wdata,
   output logic [1:0]                        rsp_voxel_state,
   output logic [vrc_pkg::FW-1:0]            rsp_freed_count,
   output logic                              rsp_in_map,
   output logic                              rsp_left_map
);

   localparam int PW = vrc_pkg::PW;
   localparam int MW = vrc_pkg::MW;
   localparam int NW = vrc_pkg::NW;
   localparam int AW = vrc_pkg::AW;

   logic [1:0] mem [vrc_pkg::DEPTH];

   logic [vrc_pkg::OXW-1:0] ox_ff;
   logic [vrc_pkg::OYW-1:0] oy_ff;
   logic [vrc_pkg::OZW-1:0] oz_ff;
   logic [vrc_pkg::NLW-1:0] near_ff;

   logic signed [PW-1:0] cx_ff, cy_ff, cz_ff;
   logic signed [PW-1:0] px_ff, py_ff, pz_ff;
   logic [MW-1:0]        ax_ff, ay_ff, az_ff;
   logic                 negx_ff, negy_ff, negz_ff;
   logic [NW-1:0]        pxy_ff, pyx_ff, pxz_ff, pzx_ff, pyz_ff, pzy_ff;
   logic [vrc_pkg::TW-1:0]  total_ff, steps_ff;
   logic [vrc_pkg::FW-1:0]  freed_ff;
   logic                 left_ff;
   logic                 inm_ff;
   logic [1:0]           ostate_ff;
   logic [1:0]           wv_ff;
   logic [AW-1:0]        iaddr_ff;
   logic [vrc_pkg::DSW-1:0] dist_ff;
   logic                 pend_ff;
   logic [AW-1:0]        paddr_ff;
   logic [AW-1:0]        clr_ff;
   logic [1:0]           rdata_ff;

   logic signed [PW-1:0] ix, iy, iz;
   logic signed [PW-1:0] oxe, oye, oze;
   logic signed [PW-1:0] dx, dy, dz;
   logic [MW-1:0]        axm, aym, azm;
   logic                 inm;

   logic [MW-1:0]        asel;
   logic [2*MW-1:0]      sqv;

   logic                 at_end;
   logic                 txy, txz, tyz;
   logic                 step_x, step_y, step_z;
   logic signed [PW-1:0] sxv, syv, szv;
   logic signed [PW-1:0] nxp, nyp, nzp;
   logic                 nin;
   logic                 walk_end;
   logic                 free_hit;
   logic [AW-1:0]        naddr;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [1:0]           wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;

   assign ix = PW'(req_coord_x);
   assign iy = PW'(req_coord_y);
   assign iz = PW'(req_coord_z);
   assign oxe = PW'(ox_ff);
   assign oye = PW'(oy_ff);
   assign oze = PW'(oz_ff);
   assign dx = ix - oxe;
   assign dy = iy - oye;
   assign dz = iz - oze;
   assign axm = MW'(dx[PW-1] ? -dx : dx);
   assign aym = MW'(dy[PW-1] ? -dy : dy);
   assign azm = MW'(dz[PW-1] ? -dz : dz);
   assign inm = vrc_pkg::in_bounds(ix, iy, iz);

   always_comb begin
      unique case (cmd.sq_sel)
         vrc_pkg::AXIS_X: asel = ax_ff;
         vrc_pkg::AXIS_Y: asel = ay_ff;
         vrc_pkg::AXIS_Z: asel = az_ff;
         default:         asel = '0;
      endcase
   end
   assign sqv = asel * asel;

   assign at_end = ((px_ff == cx_ff) && (py_ff == cy_ff) && (pz_ff == cz_ff)) ||
                   (steps_ff == total_ff);
   assign txy = (ax_ff != '0) && ((ay_ff == '0) || (pxy_ff < pyx_ff));
   assign txz = (ax_ff != '0) && ((az_ff == '0) || (pxz_ff < pzx_ff));
   assign tyz = (ay_ff != '0) && ((az_ff == '0) || (pyz_ff < pzy_ff));
   assign step_x = txy && txz;
   assign step_y = !txy && tyz;
   assign step_z = !step_x && !step_y;
   assign sxv = negx_ff ? '1 : PW'(1);
   assign syv = negy_ff ? '1 : PW'(1);
   assign szv = negz_ff ? '1 : PW'(1);
   assign nxp = step_x ? px_ff + sxv : px_ff;
   assign nyp = step_y ? py_ff + syv : py_ff;
   assign nzp = step_z ? pz_ff + szv : pz_ff;
   assign nin = vrc_pkg::in_bounds(nxp, nyp, nzp);
   assign walk_end = at_end || !nin;
   assign naddr = vrc_pkg::cell_addr(nxp, nyp, nzp);
   assign free_hit = pend_ff &&
                     ((rdata_ff == vrc_pkg::ST_UNSEEN) || (rdata_ff == vrc_pkg::ST_FRONTIER));

   assign status.clr_last = (clr_ff == AW'(vrc_pkg::DEPTH - 1));
   assign status.near = (dist_ff < vrc_pkg::DSW'(near_ff));
   assign status.walk_end = walk_end;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = iaddr_ff;
      wr_data = vrc_pkg::ST_UNSEEN;
      priority if (cmd.clear) begin
         wr_en = 1'b1;
         wr_addr = clr_ff;
      end else if (cmd.wr_item) begin
         wr_en = inm_ff;
         wr_data = wv_ff;
      end else if (cmd.mark) begin
         wr_en = inm_ff;
         wr_data = vrc_pkg::ST_OCCUPIED;
      end else if (cmd.walk) begin
         wr_en = free_hit;
         wr_addr = paddr_ff;
         wr_data = vrc_pkg::ST_EMPTY;
      end
   end

   always_comb begin
      rd_en = 1'b0;
      rd_addr = iaddr_ff;
      priority if (cmd.rd_item) begin
         rd_en = 1'b1;
      end else if (cmd.walk) begin
         rd_en = !walk_end;
         rd_addr = naddr;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff <= '0;
         oy_ff <= '0;
         oz_ff <= vrc_pkg::OZW'(3);
         near_ff <= vrc_pkg::NLW'(16);
         pend_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (vrc_pkg::csr_index_type'(csr_index))
               vrc_pkg::CSR_ORIGIN_X: ox_ff <= csr_wdata[vrc_pkg::OXW-1:0];
               vrc_pkg::CSR_ORIGIN_Y: oy_ff <= csr_wdata[vrc_pkg::OYW-1:0];
               vrc_pkg::CSR_ORIGIN_Z: oz_ff <= csr_wdata[vrc_pkg::OZW-1:0];
               vrc_pkg::CSR_NEAR_SQ:  near_ff <= csr_wdata[vrc_pkg::NLW-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.load) begin
            clr_ff <= '0;
         end else if (cmd.clear) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.mark) begin
            pend_ff <= 1'b0;
         end else if (cmd.walk) begin
            pend_ff <= !walk_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff <= ix;
         cy_ff <= iy;
         cz_ff <= iz;
         ax_ff <= axm;
         ay_ff <= aym;
         az_ff <= azm;
         negx_ff <= dx[PW-1];
         negy_ff <= dy[PW-1];
         negz_ff <= dz[PW-1];
         wv_ff <= req_write_value;
         iaddr_ff <= vrc_pkg::cell_addr(ix, iy, iz);
         freed_ff <= '0;
         left_ff <= 1'b0;
         dist_ff <= '0;
         unique case (vrc_pkg::mode_type'(req_mode))
            vrc_pkg::MODE_CAST: begin
               inm_ff <= inm;
               ostate_ff <= inm ? vrc_pkg::ST_OCCUPIED : vrc_pkg::ST_UNSEEN;
            end
            vrc_pkg::MODE_READ: begin
               inm_ff <= inm;
               ostate_ff <= vrc_pkg::ST_UNSEEN;
            end
            vrc_pkg::MODE_CLEAR: begin
               inm_ff <= 1'b0;
               ostate_ff <= vrc_pkg::ST_UNSEEN;
            end
            vrc_pkg::MODE_WRITE: begin
               inm_ff <= inm;
               ostate_ff <= inm ? req_write_value : vrc_pkg::ST_UNSEEN;
            end
            default: begin
               inm_ff <= 1'b0;
               ostate_ff <= vrc_pkg::ST_UNSEEN;
            end
         endcase
      end
      if (cmd.load) begin
         total_ff <= vrc_pkg::TW'(axm) + vrc_pkg::TW'(aym) + vrc_pkg::TW'(azm);
      end
      if (cmd.sq) begin
         dist_ff <= dist_ff + vrc_pkg::DSW'(sqv);
      end
      if (cmd.cap_rd) begin
         ostate_ff <= inm_ff ? rdata_ff : vrc_pkg::ST_UNSEEN;
      end
      if (cmd.mark) begin
         px_ff <= oxe;
         py_ff <= oye;
         pz_ff <= oze;
         pxy_ff <= NW'(ay_ff);
         pyx_ff <= NW'(ax_ff);
         pxz_ff <= NW'(az_ff);
         pzx_ff <= NW'(ax_ff);
         pyz_ff <= NW'(az_ff);
         pzy_ff <= NW'(ay_ff);
         steps_ff <= '0;
      end
      if (cmd.walk) begin
         if (free_hit && (freed_ff != vrc_pkg::FREED_MAX)) begin
            freed_ff <= freed_ff + vrc_pkg::FW'(1);
         end
         if (walk_end) begin
            if (!at_end) begin
               left_ff <= 1'b1;
            end
         end else begin
            px_ff <= nxp;
            py_ff <= nyp;
            pz_ff <= nzp;
            paddr_ff <= naddr;
            steps_ff <= steps_ff + vrc_pkg::TW'(1);
            if (step_x) begin
               pxy_ff <= pxy_ff + (NW'(ay_ff) << 1);
               pxz_ff <= pxz_ff + (NW'(az_ff) << 1);
            end
            if (step_y) begin
               pyx_ff <= pyx_ff + (NW'(ax_ff) << 1);
               pyz_ff <= pyz_ff + (NW'(az_ff) << 1);
            end
            if (step_z) begin
               pzx_ff <= pzx_ff + (NW'(ax_ff) << 1);
               pzy_ff <= pzy_ff + (NW'(ay_ff) << 1);
            end
         end
      end
   end

   assign rsp_voxel_state = ostate_ff;
   assign rsp_freed_count = freed_ff;
   assign rsp_in_map = inm_ff;
   assign rsp_left_map = left_ff;

endmodule

FILE: src/voxel_ray_cast_occupancy_update_top.sv
// Top level of the voxel ray-cast occupancy map block.
// Items enter on the req_ ports: a transfer happens at a clock edge with start high and
// busy low. Each item gives exactly one result, shown on the rsp_ ports for one cycle
// while rsp_valid is high; the receiver cannot stall it, so it must take every result.
// Configuration registers are to be written via csr_we, csr_index and csr_wdata while
// the block is idle; the block does not enforce this. A write takes effect at once.
// Each item passes through these steps before its result:
//   write voxel: one map write; read voxel: a registered map read, then the capture
//   of the read data; cast ray: the endpoint is marked occupied and the squared
//   distance to the origin is summed axis by axis; if it is near, the result follows,
//   otherwise the walker reads one voxel per cycle and writes the previous one back in
//   the same cycle until it reaches the endpoint or leaves the map;
//   clear: the whole map is set to unseen, one map entry per cycle.
// The next item is accepted in the cycle of the result, so items never overlap.
// After reset the block sweeps the whole map to unseen, one entry per cycle, keeping
// busy high meanwhile; configuration writes are taken during the sweep.
module voxel_ray_cast_occupancy_update_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic signed [vrc_pkg::CW-1:0] req_coord_x,
   input  logic signed [vrc_pkg::CW-1:0] req_coord_y,
   input  logic signed [vrc_pkg::CW-1:0] req_coord_z,
   input  logic [1:0]                    req_write_value,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_voxel_state,
   output logic [vrc_pkg::FW-1:0]        rsp_freed_count,
   output logic                          rsp_in_map,
   output logic                          rsp_left_map,
   input  logic                          csr_we,
   input  logic [vrc_pkg::CSR_IW-1:0]    csr_index,
   input  logic [vrc_pkg::CSR_DW-1:0]    csr_wdata
);

   vrc_pkg::cmd_type    cmd;
   vrc_pkg::status_type status;

   vrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   vrc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_mode),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_write_value (req_write_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_voxel_state (rsp_voxel_state),
      .rsp_freed_count (rsp_freed_count),
      .rsp_in_map      (rsp_in_map),
      .rsp_left_map    (rsp_left_map)
   );

endmodule

FILE: src/vrc_checker.sv
// Port-level checker for the voxel ray-cast occupancy block, with its bind statement.
module vrc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [1:0]             rsp_voxel_state,
   input logic [vrc_pkg::FW-1:0] rsp_freed_count,
   input logic                   rsp_in_map,
   input logic                   rsp_left_map
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted transfer did not make the block busy.");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result shown while the block is busy.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Two results in consecutive cycles.");

   a_outside_unseen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_map) |-> (rsp_voxel_state == vrc_pkg::ST_UNSEEN))
      else $error("Voxel state reported for a voxel outside the map.");

   a_left_implies_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_map && (rsp_left_map || (rsp_freed_count != '0))) |->
      (rsp_voxel_state == vrc_pkg::ST_OCCUPIED))
      else $error("Ray walked or left the map but endpoint is not occupied.");

endmodule

bind voxel_ray_cast_occupancy_update_top vrc_checker u_vrc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_voxel_state (rsp_voxel_state),
   .rsp_freed_count (rsp_freed_count),
   .rsp_in_map      (rsp_in_map),
   .rsp_left_map    (rsp_left_map)
);
